// ===== hw/rtl/rc4_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and microcode for the RC4 stream cipher engine
// Holds operation codes, step addresses, the control word and the program ROM.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int TABLE_SIZE = 256;

   localparam logic [1:0] OP_KEY_WRITE = 2'd0;
   localparam logic [1:0] OP_KEY_SCHED = 2'd1;
   localparam logic [1:0] OP_CRYPT     = 2'd2;

   typedef logic [3:0] pc_type;

   localparam pc_type PC_IDLE = 4'd0;
   localparam pc_type PC_FILL = 4'd1;
   localparam pc_type PC_KS0  = 4'd2;
   localparam pc_type PC_KS1  = 4'd3;
   localparam pc_type PC_KS2  = 4'd4;
   localparam pc_type PC_KS3  = 4'd5;
   localparam pc_type PC_EMIT = 4'd6;
   localparam pc_type PC_CR0  = 4'd7;
   localparam pc_type PC_CR1  = 4'd8;
   localparam pc_type PC_CR2  = 4'd9;
   localparam pc_type PC_CR3  = 4'd10;
   localparam pc_type PC_CR4  = 4'd11;

   typedef enum logic [2:0] {
      RD_CNT,
      RD_ACC_KS,
      RD_I_NEXT,
      RD_J_NEXT,
      RD_ACC
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_FILL,
      WR_CNT_RD,
      WR_ACC_HELD,
      WR_I_RD,
      WR_J_HELD
   } wr_sel_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_LOOP,
      JMP_DISPATCH,
      JMP_EMIT
   } jmp_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       clr_idx;
      logic       inc_cnt;
      logic       adv_kpos;
      logic       inc_i;
      logic       ld_held;
      logic       ld_acc_ks;
      logic       ld_acc_sum;
      logic       ld_j;
      logic       ld_res;
      logic       emit;
      jmp_type    jmp;
      pc_type     target;
   } ctrl_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] operation;
      logic       len_ok;
      logic       cnt_last;
      logic       slot_free;
   } seq_flags_type;

   function automatic ctrl_type ucode_rom(input pc_type pc);
      ctrl_type w;
      w = '0;
      w.rd_sel = RD_CNT;
      w.wr_sel = WR_NONE;
      w.jmp    = JMP_NEXT;
      w.target = PC_IDLE;
      case (pc)
         PC_IDLE: begin
            w.jmp = JMP_DISPATCH;
         end
         PC_FILL: begin
            w.wr_sel  = WR_FILL;
            w.inc_cnt = 1'b1;
            w.clr_idx = 1'b1;
            w.jmp     = JMP_LOOP;
            w.target  = PC_FILL;
         end
         PC_KS0: begin
            w.rd_sel = RD_CNT;
         end
         PC_KS1: begin
            w.rd_sel    = RD_ACC_KS;
            w.ld_held   = 1'b1;
            w.ld_acc_ks = 1'b1;
         end
         PC_KS2: begin
            w.wr_sel = WR_CNT_RD;
         end
         PC_KS3: begin
            w.wr_sel   = WR_ACC_HELD;
            w.inc_cnt  = 1'b1;
            w.adv_kpos = 1'b1;
            w.jmp      = JMP_LOOP;
            w.target   = PC_KS0;
         end
         PC_EMIT: begin
            w.emit   = 1'b1;
            w.jmp    = JMP_EMIT;
            w.target = PC_IDLE;
         end
         PC_CR0: begin
            w.rd_sel = RD_I_NEXT;
            w.inc_i  = 1'b1;
         end
         PC_CR1: begin
            w.rd_sel  = RD_J_NEXT;
            w.ld_held = 1'b1;
            w.ld_j    = 1'b1;
         end
         PC_CR2: begin
            w.wr_sel     = WR_I_RD;
            w.ld_acc_sum = 1'b1;
         end
         PC_CR3: begin
            w.wr_sel = WR_J_HELD;
            w.rd_sel = RD_ACC;
         end
         PC_CR4: begin
            w.ld_res = 1'b1;
            w.jmp    = JMP_ALWAYS;
            w.target = PC_EMIT;
         end
         default: begin
            w.jmp    = JMP_ALWAYS;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rc4_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_if: channel interfaces of the RC4 stream cipher engine
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] key_index;
   logic [7:0] byte_in;
   logic       last_in;

   modport source (output valid, operation, key_index, byte_in, last_in, input ready);
   modport sink (input valid, operation, key_index, byte_in, last_in, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       status;
   logic       last_out;

   modport source (output valid, byte_out, status, last_out, input ready);
   modport sink (input valid, byte_out, status, last_out, output ready);
endinterface

interface rc4_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rc4_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_sequencer: step counter and program ROM
// Fetches one control word per step and chooses the next step address.
// ----------------------------------------------------------------------------
module rc4_sequencer import rc4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  seq_flags_type flags,
   output ctrl_type      ctrl,
   output pc_type        pc
);

   pc_type pc_ff;
   pc_type pc_in;

   always_comb begin
      ctrl = ucode_rom(pc_ff);
   end

   always_comb begin
      pc_in = pc_ff + 4'd1;
      case (ctrl.jmp)
         JMP_NEXT: begin
            pc_in = pc_ff + 4'd1;
         end
         JMP_ALWAYS: begin
            pc_in = ctrl.target;
         end
         JMP_LOOP: begin
            pc_in = flags.cnt_last ? pc_ff + 4'd1 : ctrl.target;
         end
         JMP_DISPATCH: begin
            pc_in = pc_ff;
            if (flags.accept && flags.operation == OP_KEY_SCHED) begin
               pc_in = flags.len_ok ? PC_FILL : PC_EMIT;
            end else if (flags.accept && flags.operation == OP_CRYPT) begin
               pc_in = PC_CR0;
            end
         end
         JMP_EMIT: begin
            pc_in = flags.slot_free ? ctrl.target : pc_ff;
         end
         default: begin
            pc_in = PC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign pc = pc_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rc4_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_datapath: permutation table, key store, indices and result registers
// Executes the control word of each step on a one-read, one-write table.
// ----------------------------------------------------------------------------
module rc4_datapath import rc4_pkg::*; #(
   parameter int KEY_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  logic       accept,
   input  logic [1:0] operation,
   input  logic [7:0] key_index,
   input  logic [7:0] byte_in,
   input  logic       last_in,
   input  logic [8:0] key_length,
   input  logic       len_ok,
   output logic       cnt_last,
   output logic [7:0] res_byte,
   output logic       res_status,
   output logic       res_last
);

   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [8:0] KEY_BYTES_W = 9'(KEY_BYTES);

   logic [7:0]            perm_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] perm_vld_ff;
   logic [7:0]            rd_ff;
   logic                  rd_vld_ff;
   logic [7:0]            key_mem [KEY_BYTES];
   logic [7:0]            key_rd_ff;

   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;
   logic [7:0] acc_ff, acc_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] kpos_ff, kpos_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] res_ff, res_in;
   logic       status_ff, status_in;
   logic       eom_ff, eom_in;

   logic [7:0] rdv;
   logic [7:0] acc_ks;
   logic [7:0] i_next;
   logic [7:0] j_next;
   logic [7:0] sum_ab;
   logic [7:0] rd_addr;
   logic [7:0] wr_addr;
   logic [7:0] wr_data;
   logic       wr_en;
   logic       key_we;
   logic       bypass;

   assign rdv    = rd_vld_ff ? rd_ff : 8'h00;
   assign acc_ks = acc_ff + rdv + key_rd_ff;
   assign i_next = i_ff + 8'd1;
   assign j_next = j_ff + rdv;
   assign sum_ab = held_ff + rdv;

   always_comb begin
      case (ctrl.rd_sel)
         RD_CNT:    rd_addr = cnt_ff;
         RD_ACC_KS: rd_addr = acc_ks;
         RD_I_NEXT: rd_addr = i_next;
         RD_J_NEXT: rd_addr = j_next;
         RD_ACC:    rd_addr = acc_ff;
         default:   rd_addr = cnt_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cnt_ff;
      wr_data = rdv;
      case (ctrl.wr_sel)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_FILL: begin
            wr_addr = cnt_ff;
            wr_data = cnt_ff;
         end
         WR_CNT_RD: begin
            wr_addr = cnt_ff;
            wr_data = rdv;
         end
         WR_ACC_HELD: begin
            wr_addr = acc_ff;
            wr_data = held_ff;
         end
         WR_I_RD: begin
            wr_addr = i_ff;
            wr_data = rdv;
         end
         WR_J_HELD: begin
            wr_addr = j_ff;
            wr_data = held_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign bypass = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (bypass) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= perm_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            perm_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= bypass || perm_vld_ff[rd_addr];
      end
   end

   assign key_we = accept && (operation == OP_KEY_WRITE) && ({1'b0, key_index} < KEY_BYTES_W);

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_index[KIDX_W-1:0]] <= byte_in;
      end
      key_rd_ff <= key_mem[kpos_ff[KIDX_W-1:0]];
   end

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      held_in   = held_ff;
      cnt_in    = cnt_ff;
      kpos_in   = kpos_ff;
      data_in   = data_ff;
      res_in    = res_ff;
      status_in = status_ff;
      eom_in    = eom_ff;
      if (accept) begin
         data_in   = byte_in;
         res_in    = 8'h00;
         status_in = (operation == OP_KEY_SCHED) && !len_ok;
         eom_in    = (operation == OP_CRYPT) && last_in;
      end
      if (ctrl.clr_idx) begin
         i_in    = 8'h00;
         j_in    = 8'h00;
         acc_in  = 8'h00;
         kpos_in = 8'h00;
      end
      if (ctrl.inc_cnt) begin
         cnt_in = cnt_ff + 8'd1;
      end
      if (ctrl.adv_kpos) begin
         if (({1'b0, kpos_ff} + 9'd1) == key_length) begin
            kpos_in = 8'h00;
         end else begin
            kpos_in = kpos_ff + 8'd1;
         end
      end
      if (ctrl.inc_i) begin
         i_in = i_next;
      end
      if (ctrl.ld_held) begin
         held_in = rdv;
      end
      if (ctrl.ld_acc_ks) begin
         acc_in = acc_ks;
      end
      if (ctrl.ld_acc_sum) begin
         acc_in = sum_ab;
      end
      if (ctrl.ld_j) begin
         j_in = j_next;
      end
      if (ctrl.ld_res) begin
         res_in = data_ff ^ rdv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= 8'h00;
         j_ff    <= 8'h00;
         acc_ff  <= 8'h00;
         cnt_ff  <= 8'h00;
         kpos_ff <= 8'h00;
      end else begin
         i_ff    <= i_in;
         j_ff    <= j_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         kpos_ff <= kpos_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff   <= held_in;
      data_ff   <= data_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      eom_ff    <= eom_in;
   end

   assign cnt_last   = (cnt_ff == 8'hFF);
   assign res_byte   = res_ff;
   assign res_status = status_ff;
   assign res_last   = eom_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher.sv =====
`default_nettype none
// Crypt transaction: CR0 to CR4, then the emit step; requests wait for idle.
// Key schedule: 256 fill steps, then 4 steps per swap, on the permutation
// table (one read and one write port). Key byte write: no result. A bad key
// length goes straight to emit. Synchronous active-high reset clears
// control state and the table valid bits, so the table reads as zero.
// ----------------------------------------------------------------------------
// rc4_stream_cipher: RC4 stream cipher engine, top level
// Microcoded sequencer driving a table datapath, with a response register.
// ----------------------------------------------------------------------------
module rc4_stream_cipher import rc4_pkg::*; #(
   parameter int KEY_BYTES = 256
) (
   input  logic     clock,
   input  logic     reset,
   rc4_req_if.sink  req_if,
   rc4_rsp_if.source rsp_if,
   rc4_csr_if.sink  csr_if
);

   localparam logic [8:0] KEY_BYTES_W = 9'(KEY_BYTES);

   logic [8:0]    key_length_ff, key_length_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_status_ff;
   logic          rsp_last_ff;
   logic          accept;
   logic          len_ok;
   logic          slot_free;
   logic          cnt_last;
   logic [7:0]    res_byte;
   logic          res_status;
   logic          res_last;
   ctrl_type      ctrl;
   pc_type        pc;
   seq_flags_type flags;

   assign req_if.ready = (pc == PC_IDLE) && !reset;
   assign csr_if.ready = !reset;
   assign accept       = req_if.valid && req_if.ready;
   assign len_ok       = (key_length_ff != 9'd0) && (key_length_ff <= KEY_BYTES_W);
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      flags.accept    = accept;
      flags.operation = req_if.operation;
      flags.len_ok    = len_ok;
      flags.cnt_last  = cnt_last;
      flags.slot_free = slot_free;
   end

   rc4_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .pc    (pc)
   );

   rc4_datapath #(
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .accept     (accept),
      .operation  (req_if.operation),
      .key_index  (req_if.key_index),
      .byte_in    (req_if.byte_in),
      .last_in    (req_if.last_in),
      .key_length (key_length_ff),
      .len_ok     (len_ok),
      .cnt_last   (cnt_last),
      .res_byte   (res_byte),
      .res_status (res_status),
      .res_last   (res_last)
   );

   always_comb begin
      key_length_in = key_length_ff;
      if (csr_if.valid && csr_if.ready) begin
         key_length_in = csr_if.data;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 9'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_length_ff <= key_length_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && slot_free) begin
         rsp_byte_ff   <= res_byte;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.byte_out = rsp_byte_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.last_out = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc == PC_EMIT))
      else $error("response raised outside the emit step");

   a_crypt_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.operation == OP_CRYPT |=> pc == PC_CR0)
      else $error("crypt transaction did not start its program");

   a_bad_len: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.operation == OP_KEY_SCHED && !len_ok |=> pc == PC_EMIT)
      else $error("invalid key length did not answer at once");

   a_key_write: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.operation == OP_KEY_WRITE |=> pc == PC_IDLE)
      else $error("key byte write left the idle step");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RC4 stream cipher engine
// Drives key byte, key schedule, crypt and unused-code transactions with
// bursty input timing and a patterned output stall. A tracker class keeps its
// own permutation, indices, key store and key length, predicts every response
// and compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import rc4_pkg::*;

   localparam int         KEY_BYTES      = 256;
   localparam int         ITEM_TARGET    = 1800;
   localparam int         SETTLE_CYCLES  = 16;
   localparam int         HOLD_CYCLES    = 300;
   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic       STATUS_OK      = 1'b0;
   localparam logic       STATUS_BAD_LEN = 1'b1;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       status;
      logic       last_out;
   } reply_type;

   class cipher_tracker;
      logic [7:0] sbox [TABLE_SIZE];
      logic [7:0] key_bytes [KEY_BYTES];
      bit         key_written [KEY_BYTES];
      logic [7:0] pos_i;
      logic [7:0] pos_j;
      logic [8:0] key_len;
      reply_type  expected_replies [$];
      int         errors;
      int         crypt_count;
      int         sched_count;
      int         bad_len_count;
      int         key_count;

      function new();
         foreach (sbox[n]) sbox[n] = '0;
         foreach (key_bytes[n]) begin
            key_bytes[n]   = '0;
            key_written[n] = 1'b0;
         end
         pos_i         = '0;
         pos_j         = '0;
         key_len       = 9'd1;
         errors        = 0;
         crypt_count   = 0;
         sched_count   = 0;
         bad_len_count = 0;
         key_count     = 0;
      endfunction

      function void note_config(input logic [8:0] value);
         key_len = value;
      endfunction

      function bit length_valid();
         return key_len >= 1 && key_len <= KEY_BYTES;
      endfunction

      function bit key_ready();
         if (!length_valid()) return 1'b1;
         for (int n = 0; n < key_len; n++) begin
            if (!key_written[n]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void schedule_key();
         logic [7:0] held;
         logic [7:0] acc;
         int         kpos;
         for (int n = 0; n < TABLE_SIZE; n++) sbox[n] = 8'(n);
         pos_i = '0;
         pos_j = '0;
         acc   = '0;
         kpos  = 0;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (kpos >= key_len) kpos = 0;
            held      = sbox[n];
            acc       = acc + held + key_bytes[kpos];
            sbox[n]   = sbox[acc];
            sbox[acc] = held;
            kpos++;
         end
      endfunction

      function logic [7:0] next_keystream();
         logic [7:0] a;
         logic [7:0] b;
         logic [7:0] ks_pos;
         pos_i       = pos_i + 8'd1;
         a           = sbox[pos_i];
         pos_j       = pos_j + a;
         b           = sbox[pos_j];
         sbox[pos_i] = b;
         sbox[pos_j] = a;
         ks_pos      = a + b;
         return sbox[ks_pos];
      endfunction

      function void note_request(input logic [1:0] op, input logic [7:0] kidx,
                                 input logic [7:0] data, input logic last);
         reply_type r;
         r = '0;
         case (op)
            OP_KEY_WRITE: begin
               key_bytes[kidx]   = data;
               key_written[kidx] = 1'b1;
               key_count++;
            end
            OP_KEY_SCHED: begin
               if (length_valid()) begin
                  schedule_key();
                  r.status = STATUS_OK;
                  sched_count++;
               end else begin
                  r.status = STATUS_BAD_LEN;
                  bad_len_count++;
               end
               expected_replies.push_back(r);
            end
            OP_CRYPT: begin
               r.byte_out = data ^ next_keystream();
               r.status   = STATUS_OK;
               r.last_out = last;
               expected_replies.push_back(r);
               crypt_count++;
            end
            default: begin
            end
         endcase
      endfunction

      function void report(input string field, input logic [7:0] want,
                           input logic [7:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      endfunction

      function void check_response(input logic [7:0] byte_out, input logic status,
                                   input logic last_out);
         reply_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %02h/%0d/%0d",
                     $time, byte_out, status, last_out);
            return;
         end
         want = expected_replies.pop_front();
         if (byte_out !== want.byte_out) report("byte_out", want.byte_out, byte_out);
         if (status !== want.status) report("status", 8'(want.status), 8'(status));
         if (last_out !== want.last_out) report("last_out", 8'(want.last_out), 8'(last_out));
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   rc4_req_if req_ch ();
   rc4_rsp_if rsp_ch ();
   rc4_csr_if csr_ch ();

   rc4_stream_cipher #(
      .KEY_BYTES(KEY_BYTES)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   cipher_tracker sb;
   int            burst_left;
   int            items_sent;
   int            settings_used;
   int            holds_requested;
   int            holds_served;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 1000000);
      $display("simulation failed");
      $finish;
   end

   initial begin : response_sink
      int   tick;
      int   hold_left;
      logic next_ready;
      tick         = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.byte_out, rsp_ch.status, rsp_ch.last_out);
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (holds_served < holds_requested) begin
            holds_served++;
            hold_left  = HOLD_CYCLES;
            next_ready = 1'b0;
         end else begin
            case ((tick / 113) % 4)
               0: next_ready = 1'b1;
               1: next_ready = 1'($urandom_range(0, 1));
               2: next_ready = ($urandom_range(0, 3) == 0);
               default: next_ready = (tick % 3 == 0);
            endcase
         end
         rsp_ch.ready <= next_ready;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] kidx,
                            input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.key_index <= kidx;
      req_ch.byte_in   <= data;
      req_ch.last_in   <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(op, kidx, data, last);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [8:0] value);
      wait_drained();
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.note_config(value);
      settings_used++;
   endtask

   task automatic run_message_phase(input int len, input bit long_hold);
      int use_len;
      int n_msgs;
      int n_bytes;
      use_len = (len >= 1 && len <= KEY_BYTES) ? len : 0;
      for (int k = 0; k < use_len; k++)
         send_item(OP_KEY_WRITE, 8'(k), 8'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 3))
         send_item(OP_KEY_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
      send_item(OP_KEY_SCHED, 8'($urandom), 8'($urandom), 1'($urandom));
      if (long_hold) holds_requested++;
      n_msgs = $urandom_range(1, 3);
      for (int m = 0; m < n_msgs; m++) begin
         n_bytes = long_hold ? 40 : $urandom_range(1, 24);
         for (int b = 0; b < n_bytes; b++)
            send_item(OP_CRYPT, 8'($urandom), 8'($urandom), b == n_bytes - 1);
      end
   endtask

   task automatic run_mixed_phase();
      int n_items;
      int pick;
      n_items = $urandom_range(10, 30);
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            send_item(OP_KEY_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
         else if (pick == 3 && sb.key_ready())
            send_item(OP_KEY_SCHED, 8'($urandom), 8'($urandom), 1'($urandom));
         else if (pick == 9)
            send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
         else
            send_item(OP_CRYPT, 8'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase_no;
      int len;
      int pick;
      bit long_hold;
      sb              = new();
      burst_left      = 0;
      items_sent      = 0;
      settings_used   = 0;
      holds_requested = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_KEY_WRITE;
      req_ch.key_index <= '0;
      req_ch.byte_in   <= '0;
      req_ch.last_in   <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Cleared-table crypts, an unused code, then key lengths 1 (reset), 0, 2.
      send_item(OP_CRYPT, 8'h00, 8'h00, 1'b0);
      send_item(OP_CRYPT, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_KEY_WRITE, 8'h00, 8'hFF, 1'b0);
      send_item(OP_KEY_WRITE, 8'hFF, 8'h00, 1'b1);
      send_item(OP_KEY_SCHED, 8'h00, 8'h00, 1'b0);
      send_item(OP_CRYPT, 8'h00, 8'h00, 1'b0);
      send_item(OP_CRYPT, 8'h00, 8'hFF, 1'b0);
      send_item(OP_CRYPT, 8'hFF, 8'hA5, 1'b1);
      write_key_length(9'd0);
      send_item(OP_KEY_SCHED, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_CRYPT, 8'h00, 8'h5A, 1'b1);
      write_key_length(9'd2);
      send_item(OP_KEY_WRITE, 8'h01, 8'h80, 1'b0);
      send_item(OP_KEY_SCHED, 8'h00, 8'h00, 1'b0);
      send_item(OP_CRYPT, 8'h55, 8'h01, 1'b0);
      send_item(OP_CRYPT, 8'hAA, 8'hFE, 1'b1);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_no)
            0: len = KEY_BYTES;
            1: len = 1;
            2: len = 0;
            default: begin
               pick = $urandom_range(0, 29);
               if (pick < 3) len = 0;
               else if (pick == 3) len = KEY_BYTES;
               else if (pick == 4) len = $urandom_range(21, KEY_BYTES - 1);
               else len = $urandom_range(1, 20);
            end
         endcase
         write_key_length(9'(len));
         long_hold = (phase_no == 3) || ($urandom_range(0, 19) == 0);
         if (phase_no < 4 || $urandom_range(0, 9) < 7)
            run_message_phase(len, long_hold);
         else
            run_mixed_phase();
         phase_no++;
      end

      wait_drained();
      $display("Covered %0d crypt bytes, %0d key schedules and %0d rejected key lengths,",
               sb.crypt_count, sb.sched_count, sb.bad_len_count);
      $display("with %0d key byte writes, %0d key length settings and %0d long output stalls.",
               sb.key_count, settings_used, holds_requested);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_if.sv
hw/rtl/rc4_sequencer.sv
hw/rtl/rc4_datapath.sv
hw/rtl/rc4_stream_cipher.sv
tb/sv/testbench.sv
